// ===== sv/thermocouple_frame_filter_macros.svh =====
// Assertion helpers shared by the filter's modules.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef THERMOCOUPLE_FRAME_FILTER_MACROS_SVH
`define THERMOCOUPLE_FRAME_FILTER_MACROS_SVH

// Same-cycle implication.
`define TFF_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tff_pkg.sv =====
`default_nettype none

package tff_pkg;

  // window and sensor geometry
  localparam int WIN_LEN    = 8;
  localparam int SENS_CNT   = 2;
  localparam int SENS_IDX_W = (SENS_CNT > 1) ? $clog2(SENS_CNT) : 1;
  localparam int POS_W      = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
  localparam int CNT_W      = $clog2(WIN_LEN + 1);

  // field widths
  localparam int TEMP_W     = 12;
  localparam int FRAME_W    = 16;
  localparam int SEL_W      = 1;
  localparam int STATUS_W   = 2;
  localparam int FILT_W     = 20;
  localparam int CNT_OUT_W  = 4;
  localparam int FRAC_W     = 8;
  localparam int SUM_W      = TEMP_W + POS_W;
  localparam int DIV_W      = SUM_W + FRAC_W;
  localparam int STEP_W     = $clog2(DIV_W);

  // frame layout
  localparam int OPEN_BIT   = 2;
  localparam int TEMP_LSB   = 3;

  // stream packing
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_FIELD_W = STATUS_W + TEMP_W + FILT_W + CNT_OUT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // config port
  localparam int CFG_IDX_W  = 1;
  localparam logic [TEMP_W-1:0] MIN_RESET = '0;
  localparam logic [TEMP_W-1:0] MAX_RESET = '1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN = 1'b0,
    CFG_MAX = 1'b1
  } cfg_reg_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_OPEN  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic [SENS_IDX_W-1:0] sensor;
    status_e               status;
    logic [TEMP_W-1:0]     temp;
  } item_t;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] count;
    logic [FILT_W-1:0]    filtered;
    logic [TEMP_W-1:0]    temp;
    status_e              status;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/tff_front.sv =====
`default_nettype none

module tff_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [tff_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [tff_pkg::TEMP_W-1:0]    cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [tff_pkg::SEL_W-1:0]     in_sel_i,
  input  wire logic [tff_pkg::FRAME_W-1:0]   in_frame_i,
  output logic                               push_o,
  input  wire logic                          q_ready_i,
  output tff_pkg::item_t                     item_o
);
  import tff_pkg::*;

  logic [TEMP_W-1:0] min_q, max_q;
  logic [TEMP_W-1:0] temp_raw;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = q_ready_i;
  assign push_o      = in_valid_i && q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_RESET;
      max_q <= MAX_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_MIN: min_q <= cfg_data_i;
        CFG_MAX: max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign temp_raw = in_frame_i[TEMP_LSB +: TEMP_W];

  always_comb begin
    // out-of-range sensor numbers fold onto the last sensor
    if (int'(in_sel_i) >= SENS_CNT) item_o.sensor = SENS_IDX_W'(SENS_CNT - 1);
    else                            item_o.sensor = SENS_IDX_W'(in_sel_i);
    priority if (in_frame_i[OPEN_BIT]) begin
      item_o.status = ST_OPEN;
      item_o.temp   = '0;
    end else if (temp_raw < min_q || temp_raw > max_q) begin
      item_o.status = ST_RANGE;
      item_o.temp   = temp_raw;
    end else begin
      item_o.status = ST_OK;
      item_o.temp   = temp_raw;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tff_fifo.sv =====
`default_nettype none
`include "thermocouple_frame_filter_macros.svh"

module tff_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire tff_pkg::item_t push_data_i,
  output logic               push_ready_o,
  input  wire logic          pop_i,
  output logic               pop_valid_o,
  output tff_pkg::item_t     pop_data_o
);
  import tff_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign push_ready_o = (int'(cnt_q) < QUEUE_DEPTH);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (int'(p) == QUEUE_DEPTH - 1) return '0;
    return p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= ptr_inc(wr_q);
      if (do_pop)  rd_q <= ptr_inc(rd_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + QCNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - QCNT_W'(1);
    end
  end

  `TFF_ASSERT(a_cnt_bound, 1'b1, int'(cnt_q) <= QUEUE_DEPTH, "queue count over depth")
  `TFF_ASSERT_NEXT(a_cnt_up, do_push && !do_pop, cnt_q == $past(cnt_q) + QCNT_W'(1), "push lost")
  `TFF_ASSERT_NEXT(a_cnt_dn, do_pop && !do_push, cnt_q == $past(cnt_q) - QCNT_W'(1), "pop lost")

endmodule

`default_nettype wire

// ===== sv/tff_back.sv =====
`default_nettype none
`include "thermocouple_frame_filter_macros.svh"

module tff_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  input  wire tff_pkg::item_t q_data_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output tff_pkg::result_t    out_data_o
);
  import tff_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_DONE
  } state_e;

  state_e                state_q;
  logic [TEMP_W-1:0]     sample_q [SENS_CNT][WIN_LEN];
  logic [SUM_W-1:0]      sum_q    [SENS_CNT];
  logic [POS_W-1:0]      pos_q    [SENS_CNT];
  logic                  full_q   [SENS_CNT];
  logic [TEMP_W-1:0]     last_q   [SENS_CNT];

  logic [SENS_IDX_W-1:0] sens_q;
  status_e               status_q;
  logic [TEMP_W-1:0]     temp_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [CNT_W-1:0]      rem_q;
  logic [DIV_W-1:0]      div_q;
  logic [STEP_W-1:0]     step_q;
  logic                  out_valid_q;
  result_t               out_q;

  item_t                 it;
  logic [CNT_W-1:0]      cnt_d;
  logic [CNT_W:0]        rem_sh;
  logic                  ge;
  logic [CNT_W:0]        rem_nx;

  assign it          = q_data_i;
  assign q_pop_o     = q_valid_i && (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign cnt_d = full_q[sens_q] ? CNT_W'(WIN_LEN) : CNT_W'(pos_q[sens_q]);

  // restoring divide, one quotient bit per cycle shifted into div_q
  assign rem_sh = {rem_q, div_q[DIV_W-1]};
  assign ge     = (rem_sh >= {1'b0, cnt_q});
  assign rem_nx = ge ? (rem_sh - {1'b0, cnt_q}) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int s = 0; s < SENS_CNT; s++) begin
        for (int k = 0; k < WIN_LEN; k++) sample_q[s][k] <= '0;
        sum_q[s]  <= '0;
        pos_q[s]  <= '0;
        full_q[s] <= 1'b0;
        last_q[s] <= '0;
      end
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_DONE) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            sens_q   <= it.sensor;
            status_q <= it.status;
            temp_q   <= it.temp;
            last_q[it.sensor] <= it.temp;
            if (it.status == ST_OK) begin
              sum_q[it.sensor] <= sum_q[it.sensor]
                                  - SUM_W'(sample_q[it.sensor][pos_q[it.sensor]])
                                  + SUM_W'(it.temp);
              sample_q[it.sensor][pos_q[it.sensor]] <= it.temp;
              if (int'(pos_q[it.sensor]) == WIN_LEN - 1) begin
                pos_q[it.sensor]  <= '0;
                full_q[it.sensor] <= 1'b1;
              end else begin
                pos_q[it.sensor] <= pos_q[it.sensor] + POS_W'(1);
              end
            end
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          cnt_q  <= cnt_d;
          rem_q  <= '0;
          step_q <= STEP_W'(DIV_W - 1);
          if (cnt_d == '0) begin
            // empty window reports the latest reading
            div_q   <= {DIV_W'(last_q[sens_q])} << FRAC_W;
            state_q <= S_DONE;
          end else begin
            div_q   <= {sum_q[sens_q], {FRAC_W{1'b0}}};
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q  <= rem_nx[CNT_W-1:0];
          div_q  <= {div_q[DIV_W-2:0], ge};
          step_q <= step_q - STEP_W'(1);
          if (step_q == '0) state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q    <= 1'b1;
            out_q.status   <= status_q;
            out_q.temp     <= temp_q;
            out_q.filtered <= div_q[FILT_W-1:0];
            out_q.count    <= CNT_OUT_W'(cnt_q);
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `TFF_ASSERT(a_div_cnt, state_q == S_DIV, cnt_q != '0, "divide by zero count")
  `TFF_ASSERT(a_rem_bound, state_q == S_DIV, rem_q < cnt_q, "remainder not below divisor")
  `TFF_ASSERT(a_sum_bound, state_q == S_PREP, int'(sum_q[sens_q]) <= int'(cnt_d) * ((1 << TEMP_W) - 1), "window sum overflow")

endmodule

`default_nettype wire

// ===== sv/thermocouple_frame_filter.sv =====
`default_nettype none

// Thermocouple frame filter. Each accepted frame (tdata) with its sensor number (tuser)
// yields one result: status, decoded temperature in quarter degrees, the truncated mean
// of that sensor's last eight good readings in quarter degrees times 256, and the number
// of readings in the mean. In the back end a frame whose window holds readings passes
// through the window update, set-up, the bit-serial restoring divider and the hand-off
// to the output register; with an empty window the divider is skipped. The divider sets
// the rate. A two-entry queue sits between the decoding front end and the back end, so
// while the output stalls two queued frames, one finished result in the back end and one
// in the output register are held before tready drops. Range limits are written on the
// cfg port (index 0 minimum, index 1 maximum); the user must write them only while the
// block is idle, which the block itself does not enforce; reset clears all windows and
// sets the limits to the full range.
module thermocouple_frame_filter (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [tff_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [tff_pkg::TEMP_W-1:0]      cfg_data_i,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [15:0] raw_frame
  input  wire logic [tff_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] sensor_select
  input  wire logic [tff_pkg::SEL_W-1:0]       s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // [1:0] status, [13:2] temperature_quarters, [33:14] filtered_q8,
  // [37:34] filled_count, [39:38] zero
  output logic [tff_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o
);
  import tff_pkg::*;

  item_t   push_item, pop_item;
  logic    push, q_ready, q_valid, q_pop;
  result_t res;

  tff_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_sel_i    (s_axis_tuser_i),
    .in_frame_i  (s_axis_tdata_i[FRAME_W-1:0]),
    .push_o      (push),
    .q_ready_i   (q_ready),
    .item_o      (push_item)
  );

  tff_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_item),
    .push_ready_o (q_ready),
    .pop_i        (q_pop),
    .pop_valid_o  (q_valid),
    .pop_data_o   (pop_item)
  );

  tff_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_item),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (res)
  );

  assign m_axis_tdata_o = {{OUT_PAD_W{1'b0}}, res};

endmodule

`default_nettype wire
